// ===== hdl/ipt_pkg.sv =====
// Package for the IP prefix trie: defaults, field widths and request codes.
`timescale 1ns / 1ps

package ipt_pkg;

    localparam int NODES_DEF     = 1024;
    localparam int ADDR_BITS_DEF = 32;

    localparam int REQ_W  = 2;
    localparam int ADDR_W = 32;
    localparam int PLEN_W = 6;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

endpackage

// ===== hdl/ip_prefix_trie_match.sv =====
// Binary trie of IPv4 prefixes in a node memory, with insert, lookup and clear.
// An insert descends min(prefix_len, ADDR_BITS) levels, fewer when the store fills;
// a lookup descends up to ADDR_BITS levels, clear and unused codes none.
// Each trie level is one node read with its data registered, feeding
// the next read address directly; an allocation writes the parent in the same cycle.
// A new request is taken in the cycle after the result is loaded into the output register.
// Reset empties the root and sets the free counter to one; the node memory needs no pass.
`timescale 1ns / 1ps

module ip_prefix_trie_match #(
    parameter int NODES     = ipt_pkg::NODES_DEF,
    parameter int ADDR_BITS = ipt_pkg::ADDR_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [ipt_pkg::REQ_W-1:0]  i_req_type,
    input  logic [ipt_pkg::ADDR_W-1:0] i_address,
    input  logic [ipt_pkg::PLEN_W-1:0] i_prefix_len,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic                       o_found,
    output logic                       o_status
);

    import ipt_pkg::*;

    localparam int IDW = $clog2(NODES);
    localparam int NFW = IDW + 1;
    localparam int AW  = ADDR_BITS;
    localparam int DW  = $clog2(AW + 1);

    typedef struct packed {
        logic [IDW-1:0] c1;
        logic [IDW-1:0] c0;
        logic           mark;
    } t_entry;

    typedef enum logic [1:0] {S_IDLE, S_INS, S_LOOK, S_PUSH} t_state;
    typedef enum logic [1:0] {SRC_ROOT, SRC_MEM, SRC_FRESH} t_src;

    t_state         r_state, n_state;
    t_src           r_src, n_src;
    logic [IDW-1:0] r_id, n_id;
    logic [DW-1:0]  r_depth, n_depth;
    logic [DW-1:0]  r_plen, n_plen;
    logic [AW-1:0]  r_addr, n_addr;
    logic [NFW-1:0] r_next_free, n_next_free;
    t_entry         r_root, n_root;
    t_entry         r_rdata;
    logic           r_pend_found, n_pend_found;
    logic           r_pend_status, n_pend_status;
    logic           r_out_valid, r_found, r_status;

    t_entry         mem [NODES];

    logic           w_in_fire;
    logic           w_out_free;
    t_entry         w_cur;
    logic           w_bit;
    logic [IDW-1:0] w_child;
    logic [IDW-1:0] w_raddr;
    logic           w_we;
    logic [IDW-1:0] w_wid;
    t_entry         w_wdata;
    logic [DW-1:0]  w_plen;

    assign w_in_fire  = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_found    = r_found;
    assign o_status   = r_status;

    assign w_plen = (32'(i_prefix_len) > AW) ? DW'(AW) : DW'(i_prefix_len);

    always_comb begin
        case (r_src)
            SRC_ROOT: w_cur = r_root;
            SRC_MEM:  w_cur = r_rdata;
            default:  w_cur = '0;
        endcase
    end

    assign w_bit   = r_addr[AW-1];
    assign w_child = w_bit ? w_cur.c1 : w_cur.c0;
    assign w_raddr = w_child;

    always_comb begin
        n_state       = r_state;
        n_src         = r_src;
        n_id          = r_id;
        n_depth       = r_depth;
        n_plen        = r_plen;
        n_addr        = r_addr;
        n_next_free   = r_next_free;
        n_root        = r_root;
        n_pend_found  = r_pend_found;
        n_pend_status = r_pend_status;
        w_we          = 1'b0;
        w_wid         = r_id;
        w_wdata       = w_cur;
        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    n_src         = SRC_ROOT;
                    n_id          = '0;
                    n_depth       = '0;
                    n_plen        = w_plen;
                    n_addr        = AW'(i_address);
                    n_pend_found  = 1'b0;
                    n_pend_status = 1'b0;
                    case (i_req_type)
                        REQ_INSERT: n_state = S_INS;
                        REQ_LOOKUP: n_state = S_LOOK;
                        REQ_CLEAR: begin
                            n_root      = '0;
                            n_next_free = NFW'(1);
                            n_state     = S_PUSH;
                        end
                        default: n_state = S_PUSH;
                    endcase
                end
            end
            S_INS: begin
                if (r_depth == r_plen) begin
                    w_we         = 1'b1;
                    w_wdata.mark = 1'b1;
                    n_state      = S_PUSH;
                end else if (w_child != '0) begin
                    n_id    = w_child;
                    n_src   = SRC_MEM;
                    n_depth = DW'(r_depth + 1'b1);
                    n_addr  = r_addr << 1;
                end else if (r_next_free >= NFW'(NODES)) begin
                    w_we          = 1'b1;
                    n_pend_status = 1'b1;
                    n_state       = S_PUSH;
                end else begin
                    w_we = 1'b1;
                    if (w_bit) begin
                        w_wdata.c1 = r_next_free[IDW-1:0];
                    end else begin
                        w_wdata.c0 = r_next_free[IDW-1:0];
                    end
                    n_id        = r_next_free[IDW-1:0];
                    n_src       = SRC_FRESH;
                    n_next_free = NFW'(r_next_free + 1'b1);
                    n_depth     = DW'(r_depth + 1'b1);
                    n_addr      = r_addr << 1;
                end
            end
            S_LOOK: begin
                if (r_depth == DW'(AW) || w_cur.mark) begin
                    n_pend_found = 1'b1;
                    n_state      = S_PUSH;
                end else if (w_child == '0) begin
                    n_state = S_PUSH;
                end else begin
                    n_id    = w_child;
                    n_src   = SRC_MEM;
                    n_depth = DW'(r_depth + 1'b1);
                    n_addr  = r_addr << 1;
                end
            end
            S_PUSH: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (w_we && w_wid == '0) begin
            n_root = w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we && w_wid != '0) begin
            mem[w_wid] <= w_wdata;
        end
        r_rdata <= mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_next_free <= NFW'(1);
            r_root      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_next_free <= n_next_free;
            r_root      <= n_root;
            if (r_state == S_PUSH && w_out_free) begin
                r_out_valid <= 1'b1;
                r_found     <= r_pend_found;
                r_status    <= r_pend_status;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_src         <= n_src;
        r_id          <= n_id;
        r_depth       <= n_depth;
        r_plen        <= n_plen;
        r_addr        <= n_addr;
        r_pend_found  <= n_pend_found;
        r_pend_status <= n_pend_status;
    end

`ifndef SYNTH
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_free <= NFW'(NODES))
        else $error("free counter beyond node count");

    a_write_allocated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we && w_wid != '0) |-> (NFW'(w_wid) < r_next_free))
        else $error("write to unallocated node");

    a_clear_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && i_req_type == REQ_CLEAR) |=> (r_next_free == NFW'(1) && r_root == '0))
        else $error("clear did not empty the table");

    a_one_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_found && o_status))
        else $error("found and status both set");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS || r_state == S_LOOK) |-> (r_depth <= DW'(AW)))
        else $error("walk depth beyond address width");
`endif

endmodule

// ===== verif/ip_prefix_trie_match_tb.sv =====
// Testbench for ip_prefix_trie_match: directed table, fill-to-full case and random traffic.
`timescale 1ns / 1ps

module ip_prefix_trie_match_tb;

    import ipt_pkg::*;

    localparam int TRIE_NODES = NODES_DEF;
    localparam int TRIE_BITS  = ADDR_BITS_DEF;
    localparam int RANDOM_REQS = 1180;
    localparam int PREFIX_KEEP = 256;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam logic ST_DONE = 1'b0;
    localparam logic ST_FULL = 1'b1;

    typedef struct packed {
        logic found;
        logic status;
    } t_answer;

    typedef struct packed {
        logic [REQ_W-1:0]  req;
        logic [ADDR_W-1:0] addr;
        logic [PLEN_W-1:0] plen;
        logic              typed;
        logic              found;
        logic              status;
    } t_probe;

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                i_in_valid   = 1'b0;
    logic                o_in_stall;
    logic [REQ_W-1:0]    i_req_type   = '0;
    logic [ADDR_W-1:0]   i_address    = '0;
    logic [PLEN_W-1:0]   i_prefix_len = '0;
    logic                o_out_valid;
    logic                i_out_stall  = 1'b0;
    logic                o_found;
    logic                o_status;

    logic [9:0]          trie_kid [TRIE_NODES][2];
    logic                trie_mark [TRIE_NODES];
    logic [10:0]         trie_free;

    t_answer             owed_answers [$];
    t_answer             want;
    t_probe              probes [$];
    logic [ADDR_W-1:0]   stored_prefixes [$];
    logic                last_status;
    int                  mismatches  = 0;
    int                  burst_left  = 8;
    int                  stall_run   = 0;
    int                  stall_mode  = 0;

    ip_prefix_trie_match i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_req_type   (i_req_type),
        .i_address    (i_address),
        .i_prefix_len (i_prefix_len),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_found      (o_found),
        .o_status     (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void trie_clear();
        trie_kid[0][0] = '0;
        trie_kid[0][1] = '0;
        trie_mark[0]   = 1'b0;
        trie_free      = 11'd1;
    endfunction

    function automatic logic trie_insert(logic [ADDR_W-1:0] addr, logic [PLEN_W-1:0] plen);
        int span;
        int cur;
        int bitv;
        span = (plen > TRIE_BITS) ? TRIE_BITS : int'(plen);
        cur = 0;
        for (int depth = 0; depth < span; depth++) begin
            bitv = int'(addr[TRIE_BITS-1-depth]);
            if (trie_kid[cur][bitv] == '0) begin
                if (trie_free >= TRIE_NODES)
                    return ST_FULL;
                trie_kid[trie_free][0] = '0;
                trie_kid[trie_free][1] = '0;
                trie_mark[trie_free]   = 1'b0;
                trie_kid[cur][bitv]    = trie_free[9:0];
                trie_free              = trie_free + 11'd1;
            end
            cur = int'(trie_kid[cur][bitv]);
        end
        trie_mark[cur] = 1'b1;
        return ST_DONE;
    endfunction

    function automatic logic trie_lookup(logic [ADDR_W-1:0] addr);
        int cur;
        int bitv;
        cur = 0;
        for (int depth = 0; depth < TRIE_BITS; depth++) begin
            bitv = int'(addr[TRIE_BITS-1-depth]);
            if (trie_mark[cur])
                return 1'b1;
            if (trie_kid[cur][bitv] == '0)
                return 1'b0;
            cur = int'(trie_kid[cur][bitv]);
        end
        return 1'b1;
    endfunction

    task automatic add_probe(input logic [REQ_W-1:0] req, input logic [ADDR_W-1:0] addr,
                             input logic [PLEN_W-1:0] plen, input logic typed,
                             input logic found, input logic status);
        probes.push_back('{req, addr, plen, typed, found, status});
    endtask

    task automatic send_req(input logic [REQ_W-1:0] req, input logic [ADDR_W-1:0] addr,
                            input logic [PLEN_W-1:0] plen, input logic typed,
                            input logic found, input logic status);
        t_answer predicted;
        int gap;
        i_in_valid   <= 1'b1;
        i_req_type   <= req;
        i_address    <= addr;
        i_prefix_len <= plen;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        predicted = '{found: 1'b0, status: ST_DONE};
        case (req)
            REQ_INSERT: predicted.status = trie_insert(addr, plen);
            REQ_LOOKUP: predicted.found  = trie_lookup(addr);
            REQ_CLEAR:  trie_clear();
            default:    ;
        endcase
        last_status = predicted.status;
        if (typed)
            owed_answers.push_back('{found: found, status: status});
        else
            owed_answers.push_back(predicted);
        burst_left--;
        if (burst_left <= 0) begin
            gap = $urandom_range(1, 12);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 80 : 12);
        end
    endtask

    always @(posedge i_clk) begin
        if (stall_run == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_run  <= $urandom_range(5, 60);
        end else begin
            stall_run <= stall_run - 1;
        end
        case (stall_mode)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= ($urandom_range(0, 9) < 4);
            default: i_out_stall <= ($urandom_range(0, 9) < 8);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (owed_answers.size() == 0) begin
                $display("%0t: unexpected transfer, expected none, got found %0b status %0b",
                         $time, o_found, o_status);
                mismatches++;
            end else begin
                want = owed_answers.pop_front();
                if (o_found !== want.found) begin
                    $display("%0t: found mismatch, expected %0b, got %0b",
                             $time, want.found, o_found);
                    mismatches++;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status mismatch, expected %0b, got %0b",
                             $time, want.status, o_status);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int                pick;
        int                keep;
        int                lensel;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] keep_mask;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] first_fill;
        logic [PLEN_W-1:0] plen;

        for (int i = 0; i < TRIE_NODES; i++) begin
            trie_kid[i][0] = '0;
            trie_kid[i][1] = '0;
            trie_mark[i]   = 1'b0;
        end
        trie_clear();

        add_probe(REQ_LOOKUP, 32'h0000_0000, 6'd0,  1'b1, 1'b0, ST_DONE);
        add_probe(REQ_LOOKUP, 32'hFFFF_FFFF, 6'd63, 1'b1, 1'b0, ST_DONE);
        add_probe(REQ_UNUSED, 32'hFFFF_FFFF, 6'd63, 1'b1, 1'b0, ST_DONE);
        add_probe(REQ_UNUSED, 32'h0000_0000, 6'd0,  1'b1, 1'b0, ST_DONE);
        add_probe(REQ_INSERT, 32'hC0A8_0000, 6'd16, 1'b1, 1'b0, ST_DONE);
        add_probe(REQ_LOOKUP, 32'hC0A8_1234, 6'd0,  1'b1, 1'b1, ST_DONE);
        add_probe(REQ_LOOKUP, 32'hC0A9_0000, 6'd0,  1'b0, 1'b0, ST_DONE);
        add_probe(REQ_INSERT, 32'h0A00_0000, 6'd8,  1'b1, 1'b0, ST_DONE);
        add_probe(REQ_LOOKUP, 32'h0AFF_FFFF, 6'd0,  1'b1, 1'b1, ST_DONE);
        add_probe(REQ_INSERT, 32'hFFFF_FFFF, 6'd32, 1'b1, 1'b0, ST_DONE);
        add_probe(REQ_LOOKUP, 32'hFFFF_FFFF, 6'd0,  1'b1, 1'b1, ST_DONE);
        add_probe(REQ_LOOKUP, 32'hFFFF_FFFE, 6'd0,  1'b0, 1'b0, ST_DONE);
        add_probe(REQ_LOOKUP, 32'h7FFF_FFFF, 6'd0,  1'b0, 1'b0, ST_DONE);
        add_probe(REQ_INSERT, 32'h1234_5678, 6'd63, 1'b1, 1'b0, ST_DONE);
        add_probe(REQ_LOOKUP, 32'h1234_5678, 6'd0,  1'b1, 1'b1, ST_DONE);
        add_probe(REQ_LOOKUP, 32'h1234_5679, 6'd0,  1'b0, 1'b0, ST_DONE);
        add_probe(REQ_INSERT, 32'h0000_0000, 6'd33, 1'b1, 1'b0, ST_DONE);
        add_probe(REQ_LOOKUP, 32'h0000_0000, 6'd0,  1'b1, 1'b1, ST_DONE);
        add_probe(REQ_CLEAR,  32'h5A5A_5A5A, 6'd21, 1'b1, 1'b0, ST_DONE);
        add_probe(REQ_LOOKUP, 32'hC0A8_1234, 6'd0,  1'b1, 1'b0, ST_DONE);
        add_probe(REQ_INSERT, 32'hA5A5_A5A5, 6'd0,  1'b1, 1'b0, ST_DONE);
        add_probe(REQ_LOOKUP, 32'h5A5A_5A5A, 6'd0,  1'b1, 1'b1, ST_DONE);
        add_probe(REQ_INSERT, 32'h8000_0000, 6'd1,  1'b0, 1'b0, ST_DONE);
        add_probe(REQ_CLEAR,  32'h0000_0000, 6'd0,  1'b1, 1'b0, ST_DONE);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (probes[k])
            send_req(probes[k].req, probes[k].addr, probes[k].plen,
                     probes[k].typed, probes[k].found, probes[k].status);

        // fill the node store until an insert aborts
        first_fill = $urandom;
        addr = first_fill;
        send_req(REQ_INSERT, first_fill, 6'd32, 1'b1, 1'b0, ST_DONE);
        while (last_status != ST_FULL) begin
            addr = $urandom;
            send_req(REQ_INSERT, addr, 6'd32, 1'b0, 1'b0, ST_DONE);
        end
        send_req(REQ_INSERT, first_fill, 6'd32, 1'b0, 1'b0, ST_DONE);
        send_req(REQ_LOOKUP, first_fill, 6'd0, 1'b1, 1'b1, ST_DONE);
        send_req(REQ_LOOKUP, addr, 6'd0, 1'b0, 1'b0, ST_DONE);
        send_req(REQ_INSERT, addr, 6'd4, 1'b0, 1'b0, ST_DONE);
        send_req(REQ_CLEAR, $urandom, 6'($urandom_range(0, 63)), 1'b1, 1'b0, ST_DONE);

        for (int n = 0; n < RANDOM_REQS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
                send_req(REQ_CLEAR, $urandom, 6'($urandom_range(0, 63)), 1'b0, 1'b0, ST_DONE);
                stored_prefixes.delete();
            end else if (pick < 4) begin
                send_req(REQ_UNUSED, $urandom, 6'($urandom_range(0, 63)), 1'b0, 1'b0, ST_DONE);
            end else if (pick < 44) begin
                lensel = $urandom_range(0, 199);
                if (lensel == 0)
                    plen = 6'd0;
                else if (lensel < 12)
                    plen = 6'($urandom_range(33, 63));
                else if (lensel < 40)
                    plen = 6'($urandom_range(1, 8));
                else
                    plen = 6'($urandom_range(9, 32));
                addr = $urandom;
                if (stored_prefixes.size() != 0 && $urandom_range(0, 9) < 3) begin
                    base = stored_prefixes[$urandom_range(0, stored_prefixes.size() - 1)];
                    keep = $urandom_range(0, 32);
                    keep_mask = (keep == 0) ? '0 : ~32'h0 << (32 - keep);
                    addr = (base & keep_mask) | (addr & ~keep_mask);
                end
                send_req(REQ_INSERT, addr, plen, 1'b0, 1'b0, ST_DONE);
                stored_prefixes.push_back(addr);
                if (stored_prefixes.size() > PREFIX_KEEP)
                    void'(stored_prefixes.pop_front());
            end else begin
                addr = $urandom;
                if (stored_prefixes.size() != 0 && $urandom_range(0, 3) != 0) begin
                    base = stored_prefixes[$urandom_range(0, stored_prefixes.size() - 1)];
                    keep = $urandom_range(0, 32);
                    keep_mask = (keep == 0) ? '0 : ~32'h0 << (32 - keep);
                    addr = (base & keep_mask) | (addr & ~keep_mask);
                end
                send_req(REQ_LOOKUP, addr, 6'($urandom_range(0, 63)), 1'b0, 1'b0, ST_DONE);
            end
        end

        if (i_in_valid)
            i_in_valid <= 1'b0;
        while (owed_answers.size() != 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== ip_prefix_trie_match.f =====
hdl/ipt_pkg.sv
hdl/ip_prefix_trie_match.sv
verif/ip_prefix_trie_match_tb.sv
